[rtl/core/bounded_ordered_list_engine_top_assert.svh]
// Assertion macros used by the checker of the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// Clocked assertion that is held off while reset is asserted.
`define BOLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BOLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/bole_pkg.sv]
// Package with shared codes, constants and types of the ordered list engine.
package bole_pkg;

    // Default number of list cells.
    localparam int CAPACITY_DEFAULT = 16;

    // Packed widths of the stream payloads.
    localparam int IN_W  = 40;
    localparam int OUT_W = 40;

    // Command codes.
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_RM_FRONT  = 3'd2;
    localparam logic [2:0] CMD_RM_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH    = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;
    localparam logic [2:0] CMD_INS_AT    = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_out;
    } ctl_cmd_t;

endpackage

[rtl/core/bole_datapath.sv]
// Datapath of the ordered list engine: list cells, count, command execution and result register.
module bole_datapath #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bole_pkg::ctl_cmd_t         ctl,
    input  logic [bole_pkg::IN_W-1:0]  s_tdata,
    output logic [bole_pkg::OUT_W-1:0] m_tdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam int RDN  = (CAPACITY < 16) ? CAPACITY : 16;

    logic [31:0]   cells_reg [CAPACITY];
    logic [31:0]   cells_next [CAPACITY];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [2:0]    cmd_reg;
    logic [31:0]   val_reg;
    logic [3:0]    pos_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [31:0]   rd_reg;
    logic [31:0]   rd_next;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;
    logic [bole_pkg::OUT_W-1:0] out_tdata_reg;

    logic [CMPW-1:0] cnt_cmp;
    logic [CMPW-1:0] pos_cmp;
    logic            full;
    logic            empty;
    logic            pos_bad;
    logic            do_ins;
    logic            do_rmf;
    logic            do_rmb;
    logic            do_srch;
    logic [CW-1:0]   ins_at;
    logic [31:0]     rd_sel;
    logic [4:0]      cnt_wide;

    // Range checks on the current count and the requested position.
    assign cnt_cmp = CMPW'(count_reg);
    assign pos_cmp = CMPW'(pos_reg);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_bad = (pos_cmp >= cnt_cmp);

    // Read port for the read-index command; positions reach at most sixteen cells.
    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < RDN; i++) begin
            if (pos_reg == 4'(i)) begin
                rd_sel = cells_reg[i];
            end
        end
    end

    // Command decode: status, read data and which list operation to perform.
    always_comb begin
        status_next = bole_pkg::ST_OK;
        rd_next     = '0;
        do_ins      = 1'b0;
        do_rmf      = 1'b0;
        do_rmb      = 1'b0;
        do_srch     = 1'b0;
        ins_at      = '0;
        case (cmd_reg)
            bole_pkg::CMD_INS_FRONT: begin
                if (full) begin
                    status_next = bole_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            bole_pkg::CMD_INS_BACK: begin
                if (full) begin
                    status_next = bole_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    ins_at = count_reg;
                end
            end
            bole_pkg::CMD_RM_FRONT: begin
                if (empty) begin
                    status_next = bole_pkg::ST_EMPTY;
                end else begin
                    do_rmf = 1'b1;
                end
            end
            bole_pkg::CMD_RM_BACK: begin
                if (empty) begin
                    status_next = bole_pkg::ST_EMPTY;
                end else begin
                    do_rmb = 1'b1;
                end
            end
            bole_pkg::CMD_SEARCH: begin
                do_srch = 1'b1;
            end
            bole_pkg::CMD_READ: begin
                if (pos_bad) begin
                    status_next = bole_pkg::ST_BADIDX;
                end else begin
                    rd_next = rd_sel;
                end
            end
            bole_pkg::CMD_INS_AT: begin
                if (pos_bad) begin
                    status_next = bole_pkg::ST_BADIDX;
                end else if (full) begin
                    status_next = bole_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    ins_at = CW'(pos_reg);
                end
            end
            default: begin
                status_next = bole_pkg::ST_OK;
            end
        endcase
    end

    // Each cell takes its own value, the inserted value, its front neighbor's or its back neighbor's.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_comb begin
            cells_next[g] = cells_reg[g];
            if (do_ins) begin
                if (CW'(g) == ins_at) begin
                    cells_next[g] = val_reg;
                end else if (CW'(g) > ins_at) begin
                    if (g > 0) begin
                        cells_next[g] = cells_reg[(g > 0) ? g - 1 : 0];
                    end
                end
            end else if (do_rmf) begin
                if (g < CAPACITY - 1) begin
                    cells_next[g] = cells_reg[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end

        // Per-cell match flag for a search, limited to occupied cells.
        assign match_next[g] = do_srch && (cells_reg[g] == val_reg) && (CW'(g) < count_reg);
    end

    // New count after the operation.
    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_rmf || do_rmb) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.exec) begin
            count_reg <= count_next;
        end
    end

    // Input capture, cell update, per-command results and the output payload.
    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            cmd_reg <= s_tdata[2:0];
            val_reg <= s_tdata[34:3];
            pos_reg <= s_tdata[38:35];
        end
        if (ctl.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                cells_reg[i] <= cells_next[i];
            end
            status_reg <= status_next;
            rd_reg     <= rd_next;
            match_reg  <= match_next;
        end
        if (ctl.load_out) begin
            out_tdata_reg <= {cnt_wide, rd_reg, |match_reg, status_reg};
        end
    end

    // The count field carries the count modulo 32.
    assign cnt_wide = 5'(count_reg);
    assign m_tdata  = out_tdata_reg;

endmodule

[rtl/core/bole_ctrl.sv]
// Controller of the ordered list engine: sequences capture, execution and result handoff.
module bole_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output bole_pkg::ctl_cmd_t ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    // The result register can be loaded when it is empty or being drained.
    assign slot_free = !out_valid_reg || m_tready;

    // Commands to the datapath.
    always_comb begin
        ctl.latch_in = (state_reg == ST_IDLE) && s_tvalid;
        ctl.exec     = (state_reg == ST_EXEC);
        ctl.load_out = (state_reg == ST_FIN) && slot_free;
    end

    // State and output-valid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/core/bounded_ordered_list_engine_top.sv]
// Top level of the ordered list engine: stream ports, controller and datapath.
// The engine keeps up to CAPACITY signed 32-bit values in list order in one register cell
// each and runs one command per input transaction, returning one result transaction.
// The command is captured at the edge that accepts it, all cells shift or compare in
// parallel in the next cycle, and the result register is then loaded in the final step
// once it is free. A new command is accepted once the previous one has reached the
// result register; a result still waiting there holds the following command in its final
// step until the result transaction completes. Search compares all cells at once and ORs
// the match flags in the result cycle. Read index reaches the first sixteen cells, as the
// position field is four bits wide. The count field reports the count modulo 32.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: command[2:0], value[34:3], position[38:35], zero fill [39].
    input  logic [bole_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // Fields from bit 0: status[1:0], found[2], read_value[34:3], count[39:35].
    output logic [bole_pkg::OUT_W-1:0] m_tdata
);

    bole_pkg::ctl_cmd_t ctl;

    // Sequencing of each transaction.
    bole_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    // List storage and command execution.
    bole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

[rtl/core/bole_checker.sv]
// Port-level checker of the ordered list engine and its bind to the top level.
`include "bounded_ordered_list_engine_top_assert.svh"

module bole_checker #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEFAULT
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bole_pkg::OUT_W-1:0] m_tdata
);

    // A stalled result stays valid and unchanged.
    `BOLE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The reported count never exceeds the capacity.
    `BOLE_ASSERT(a_count_range, m_tvalid |-> (CAPACITY > 31) || (m_tdata[39:35] <= CAPACITY), "count above capacity")

    // A found flag and nonzero read data never come together, and either only comes with an ok status.
    `BOLE_ASSERT(a_found_ok, m_tvalid && m_tdata[2] && m_tdata[34:3] != 32'd0 |-> 1'b0, "search and read results mixed")
    `BOLE_ASSERT(a_data_ok, m_tvalid && (m_tdata[2] || m_tdata[34:3] != 32'd0) |-> m_tdata[1:0] == bole_pkg::ST_OK, "result data with failing status")

    // No result is offered in the cycle after reset.
    `BOLE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind bounded_ordered_list_engine_top bole_checker #(.CAPACITY(CAPACITY)) u_bole_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the bounded ordered list engine.
`timescale 1ns / 1ps

module tb;

    localparam int CAP          = bole_pkg::CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS = 1250;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    // The one command code that the engine leaves unused.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_t;

    // One expected result transaction, field by field.
    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [31:0] read_value;
        logic [4:0]  count;
    } reply_t;

    // Shadow copy of the list that predicts every result and checks it on arrival.
    class list_shadow;
        logic [31:0] cells [CAP];
        int          fill;
        reply_t      pending [$];
        int          errors;
        int          commands;
        int          checked;
        int          n_full;
        int          n_empty;
        int          n_badidx;
        int          n_hits;

        // Shift the cells at and behind the insertion point back by one and place the value there.
        function void open_gap(int at, logic [31:0] val);
            for (int i = fill; i > at; i--) begin
                cells[i] = cells[i - 1];
            end
            cells[at] = val;
            fill++;
        endfunction

        // Apply one accepted command to the shadow list and queue its result.
        function void note_command(logic [2:0] cmd, logic [31:0] val, logic [3:0] pos);
            reply_t r;
            r.status     = bole_pkg::ST_OK;
            r.found      = 1'b0;
            r.read_value = '0;
            commands++;
            case (cmd)
                bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK: begin
                    if (fill >= CAP) r.status = bole_pkg::ST_FULL;
                    else open_gap((cmd == bole_pkg::CMD_INS_FRONT) ? 0 : fill, val);
                end
                bole_pkg::CMD_RM_FRONT: begin
                    if (fill == 0) begin
                        r.status = bole_pkg::ST_EMPTY;
                    end else begin
                        for (int i = 1; i < fill; i++) cells[i - 1] = cells[i];
                        fill--;
                    end
                end
                bole_pkg::CMD_RM_BACK: begin
                    if (fill == 0) r.status = bole_pkg::ST_EMPTY;
                    else fill--;
                end
                bole_pkg::CMD_SEARCH: begin
                    for (int i = 0; i < fill; i++) begin
                        if (cells[i] == val) r.found = 1'b1;
                    end
                end
                bole_pkg::CMD_READ: begin
                    if (int'(pos) >= fill) r.status = bole_pkg::ST_BADIDX;
                    else r.read_value = cells[pos];
                end
                bole_pkg::CMD_INS_AT: begin
                    if (int'(pos) >= fill) r.status = bole_pkg::ST_BADIDX;
                    else if (fill >= CAP) r.status = bole_pkg::ST_FULL;
                    else open_gap(int'(pos), val);
                end
                default: begin
                end
            endcase
            r.count = fill[4:0];
            pending.push_back(r);
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_reply(logic [bole_pkg::OUT_W-1:0] data);
            reply_t want;
            if (pending.size() == 0) begin
                $display("%0t: result %h arrived with no command outstanding", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.status == bole_pkg::ST_FULL)   n_full++;
            if (want.status == bole_pkg::ST_EMPTY)  n_empty++;
            if (want.status == bole_pkg::ST_BADIDX) n_badidx++;
            if (want.found)                         n_hits++;
            compare_field("status", 32'(want.status), 32'(data[1:0]));
            compare_field("found", 32'(want.found), 32'(data[2]));
            compare_field("read_value", want.read_value, data[34:3]);
            compare_field("count", 32'(want.count), 32'(data[39:35]));
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    // Fields from bit 0: command[2:0], value[34:3], position[38:35], zero fill [39].
    logic [bole_pkg::IN_W-1:0]  s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    // Fields from bit 0: status[1:0], found[2], read_value[34:3], count[39:35].
    logic [bole_pkg::OUT_W-1:0] m_tdata;

    list_shadow shadow = new;

    bit tail_phase;
    bit source_calm;
    bit sink_calm;
    bit hold_off_req;
    int stall_cycles;

    bounded_ordered_list_engine_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one command and hold it until the engine accepts the transaction.
    task automatic issue_command(logic [2:0] cmd, logic [31:0] val, logic [3:0] pos);
        int gap;
        if (!tail_phase && !source_calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, val, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [2:0] pick_command(mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return CMD_UNUSED;
        if (mix == MIX_GROW && roll < 60) begin
            case ($urandom_range(0, 2))
                0:       return bole_pkg::CMD_INS_FRONT;
                1:       return bole_pkg::CMD_INS_BACK;
                default: return bole_pkg::CMD_INS_AT;
            endcase
        end
        if (mix == MIX_SHRINK && roll < 60) begin
            return ($urandom_range(0, 1) == 0) ? bole_pkg::CMD_RM_FRONT : bole_pkg::CMD_RM_BACK;
        end
        return 3'($urandom_range(int'(bole_pkg::CMD_INS_FRONT), int'(bole_pkg::CMD_INS_AT)));
    endfunction

    // Searches often look for a value that is present; other values lean on the extremes.
    function automatic logic [31:0] pick_value(logic [2:0] cmd);
        int fill;
        fill = shadow.fill;
        if (cmd == bole_pkg::CMD_SEARCH && fill > 0 && $urandom_range(0, 1) == 0) begin
            return shadow.cells[$urandom_range(0, fill - 1)];
        end
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 7));
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_position();
        int fill;
        fill = shadow.fill;
        if (fill > 0 && $urandom_range(0, 1) == 0) return 4'($urandom_range(0, fill - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // Reset and command source.
    initial begin : command_source
        mix_t        mix;
        int          phase_left;
        logic [2:0]  cmd;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty-list cases, extreme values, index checks, unused code.
        issue_command(bole_pkg::CMD_RM_FRONT, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_RM_BACK, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_READ, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_SEARCH, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_INS_AT, 32'h1234_5678, 4'd0);
        issue_command(CMD_UNUSED, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_INS_FRONT, 32'h8000_0000, 4'd0);
        issue_command(bole_pkg::CMD_INS_BACK, 32'h7FFF_FFFF, 4'd0);
        issue_command(bole_pkg::CMD_INS_FRONT, 32'h0000_0000, 4'd0);
        issue_command(bole_pkg::CMD_INS_BACK, 32'hFFFF_FFFF, 4'd0);
        issue_command(bole_pkg::CMD_INS_AT, 32'h5555_5555, 4'd1);
        issue_command(bole_pkg::CMD_INS_AT, 32'h0BAD_0BAD, 4'd5);
        issue_command(bole_pkg::CMD_READ, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_READ, 32'h0, 4'd2);
        issue_command(bole_pkg::CMD_READ, 32'h0, 4'd4);
        issue_command(bole_pkg::CMD_READ, 32'h0, 4'd5);
        issue_command(bole_pkg::CMD_READ, 32'h0, 4'd15);
        issue_command(bole_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 4'd0);
        issue_command(bole_pkg::CMD_SEARCH, 32'h1234_5678, 4'd0);
        issue_command(bole_pkg::CMD_RM_FRONT, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_RM_BACK, 32'h0, 4'd0);
        issue_command(bole_pkg::CMD_INS_AT, 32'hAAAA_AAAA, 4'd15);
        issue_command(CMD_UNUSED, 32'hFFFF_FFFF, 4'd15);

        // Random part: phases that lean toward growing, shrinking or a mix.
        phase_left = 0;
        mix        = MIX_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_SHRINK;
                    default: mix = MIX_ANY;
                endcase
                phase_left  = $urandom_range(15, 60);
                source_calm = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if (n == HOLD_AT_ITEM) hold_off_req = 1'b1;
            if (n == RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
            cmd = pick_command(mix);
            issue_command(cmd, pick_value(cmd), pick_position());
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then allow for the pipeline depth.
        while (shadow.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, shadow.pending.size());
            shadow.errors++;
        end

        $display("Ran %0d commands and checked %0d results, with one long output hold-off.",
                 shadow.commands, shadow.checked);
        $display("Statuses seen: %0d full, %0d empty, %0d bad index; %0d search hits.",
                 shadow.n_full, shadow.n_empty, shadow.n_badidx, shadow.n_hits);
        if (shadow.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Result sink with random back-pressure and one long hold-off.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!tail_phase && !sink_calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
        end
    end

    // Transaction monitor and watchdog on cycles without progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                shadow.note_command(s_tdata[2:0], s_tdata[34:3], s_tdata[38:35]);
            end
            if (m_tvalid && m_tready) begin
                shadow.check_reply(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
